// ----- rtl/core/aes128_pkg.sv -----
// AES-128 shared types, S-box tables and round helper functions.
package aes128_pkg;

  typedef logic [127:0] blk_t;
  typedef logic [7:0]   byte_t;

  // cycles the round key chain needs to settle after a key change
  localparam logic [3:0] KeySettle = 4'd11;

  localparam logic [1:0] AddrKeyHigh = 2'd0;
  localparam logic [1:0] AddrKeyLow  = 2'd1;

  localparam logic CmdEncrypt = 1'b0;
  localparam logic CmdDecrypt = 1'b1;

  localparam logic [2047:0] FwdBox = {
    128'h16bb54b00f2d99416842e6bf0d89a18c,
    128'hdf2855cee9871e9b948ed9691198f8e1,
    128'h9e1dc186b95735610ef6034866b53e70,
    128'h8a8bbd4b1f74dde8c6b4a61c2e2578ba,
    128'h08ae7a65eaf4566ca94ed58d6d37c8e7,
    128'h79e4959162acd3c25c2406490a3a32e0,
    128'hdb0b5ede14b8ee4688902a22dc4f8160,
    128'h73195d643d7ea7c41744975fec130ccd,
    128'hd2f3ff1021dab6bcf5389d928f40a351,
    128'ha89f3c507f02f94585334d43fbaaefd0,
    128'hcf584c4a39becb6a5bb1fc20ed00d153,
    128'h842fe329b3d63b52a05a6e1b1a2c8309,
    128'h75b227ebe28012079a059618c323c704,
    128'h1531d871f1e5a534ccf73f362693fdb7,
    128'hc072a49cafa2d4adf04759fa7dc982ca,
    128'h76abd7fe2b670130c56f6bf27b777c63
  };

  localparam logic [2047:0] InvBox = {
    128'h7d0c2155631469e126d677ba7e042b17,
    128'h619953833cbbebc8b0f52aae4d3be0a0,
    128'hef9cc9939f7ae52d0d4ab519a97f5160,
    128'h5fec8027591012b131c7078833a8dd1f,
    128'hf45acd78fec0db9a2079d2c64b3e56fc,
    128'h1bbe18aa0e62b76f89c5291d711af147,
    128'h6edf751ce837f9e28535ade72274ac96,
    128'h73e6b4f0cecff297eadc674f4111913a,
    128'h6b8a130103bdafc1020f3fca8f1e2cd0,
    128'h0645b3b80558e4f70ad3bc8c00abd890,
    128'h849d8da75746155edab9edfd5048706c,
    128'h92b6655dcc5ca4d41698688664f6f872,
    128'h25d18b6d49a25b76b224d92866a12e08,
    128'h4ec3fa420b954cee3d23c2a632947b54,
    128'hcbe9dec444438e3487ff2f9b8239e37c,
    128'hfbd7f3819ea340bf38a53630d56a0952
  };

  function automatic byte_t sbox(input byte_t b);
    sbox = FwdBox[{b, 3'b000} +: 8];
  endfunction

  function automatic byte_t inv_sbox(input byte_t b);
    inv_sbox = InvBox[{b, 3'b000} +: 8];
  endfunction

  function automatic byte_t xt(input byte_t b);
    xt = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the block sits at bits [127-8i -: 8]
  function automatic byte_t get_b(input blk_t s, input int i);
    get_b = s[127 - 8 * i -: 8];
  endfunction

  function automatic blk_t enc_round(input blk_t s, input blk_t k, input logic last);
    blk_t  t;
    blk_t  m;
    byte_t a0, a1, a2, a3;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127 - 8 * (r + 4 * c) -: 8] = sbox(get_b(s, r + 4 * ((c + r) % 4)));
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = get_b(t, 4 * c);
      a1 = get_b(t, 4 * c + 1);
      a2 = get_b(t, 4 * c + 2);
      a3 = get_b(t, 4 * c + 3);
      m[127 - 32 * c -: 8]      = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      m[127 - 32 * c - 8 -: 8]  = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      m[127 - 32 * c - 16 -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      m[127 - 32 * c - 24 -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    enc_round = (last ? t : m) ^ k;
  endfunction

  function automatic byte_t mulc(input byte_t b, input byte_t c);
    byte_t x2, x4, x8;
    x2 = xt(b);
    x4 = xt(x2);
    x8 = xt(x4);
    mulc = (c[0] ? b : 8'h00) ^ (c[1] ? x2 : 8'h00) ^ (c[2] ? x4 : 8'h00) ^
           (c[3] ? x8 : 8'h00);
  endfunction

  // inverse round: AddRoundKey, InvMixColumns (skipped on first), InvShiftRows, InvSubBytes
  function automatic blk_t dec_round(input blk_t s, input blk_t k, input logic first);
    blk_t  a;
    blk_t  m;
    blk_t  t;
    byte_t a0, a1, a2, a3;
    a = s ^ k;
    for (int c = 0; c < 4; c++) begin
      a0 = get_b(a, 4 * c);
      a1 = get_b(a, 4 * c + 1);
      a2 = get_b(a, 4 * c + 2);
      a3 = get_b(a, 4 * c + 3);
      m[127 - 32 * c -: 8]      = mulc(a0, 8'h0e) ^ mulc(a1, 8'h0b) ^ mulc(a2, 8'h0d) ^
                                  mulc(a3, 8'h09);
      m[127 - 32 * c - 8 -: 8]  = mulc(a0, 8'h09) ^ mulc(a1, 8'h0e) ^ mulc(a2, 8'h0b) ^
                                  mulc(a3, 8'h0d);
      m[127 - 32 * c - 16 -: 8] = mulc(a0, 8'h0d) ^ mulc(a1, 8'h09) ^ mulc(a2, 8'h0e) ^
                                  mulc(a3, 8'h0b);
      m[127 - 32 * c - 24 -: 8] = mulc(a0, 8'h0b) ^ mulc(a1, 8'h0d) ^ mulc(a2, 8'h09) ^
                                  mulc(a3, 8'h0e);
    end
    if (first) m = a;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = inv_sbox(get_b(m, r + 4 * c));
      end
    end
    dec_round = t;
  endfunction

  function automatic blk_t next_rk(input blk_t p, input byte_t rcon);
    blk_t  n;
    byte_t t0, t1, t2, t3;
    t0 = sbox(get_b(p, 13)) ^ rcon;
    t1 = sbox(get_b(p, 14));
    t2 = sbox(get_b(p, 15));
    t3 = sbox(get_b(p, 12));
    n[127:96] = p[127:96] ^ {t0, t1, t2, t3};
    n[95:64]  = n[127:96] ^ p[95:64];
    n[63:32]  = n[95:64] ^ p[63:32];
    n[31:0]   = n[63:32] ^ p[31:0];
    next_rk = n;
  endfunction

endpackage

// ----- rtl/core/aes128_keyexp.sv -----
// Round key expansion in a chain of registers that follows the key.
module aes128_keyexp (
  input  logic                   clk,
  input  aes128_pkg::blk_t       key,
  output aes128_pkg::blk_t [10:0] rk
);

  localparam logic [79:0] Rcon = 80'h36_1b_80_40_20_10_08_04_02_01;

  aes128_pkg::blk_t [10:0] rk_r;
  aes128_pkg::blk_t [10:0] rk_nxt;

  // one key step per stage; the top level holds off requests until
  // the chain has settled after a key write
  always_comb begin
    rk_nxt[0] = key;
    for (int i = 1; i <= 10; i++) begin
      rk_nxt[i] = aes128_pkg::next_rk(rk_r[i - 1], Rcon[8 * (i - 1) +: 8]);
    end
  end

  always_ff @(posedge clk) begin
    rk_r <= rk_nxt;
  end

  assign rk = rk_r;

endmodule

// ----- rtl/core/aes128_round.sv -----
// One pipelined cipher round stage for both directions.
module aes128_round (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [3:0]       idx,
  input  logic             in_vld,
  input  logic             in_cmd,
  input  aes128_pkg::blk_t in_s,
  input  aes128_pkg::blk_t ekey,
  input  aes128_pkg::blk_t dkey,
  output logic             out_vld,
  output logic             out_cmd,
  output aes128_pkg::blk_t out_s
);

  logic             vld_r;
  logic             cmd_r;
  aes128_pkg::blk_t s_r;
  aes128_pkg::blk_t s_nxt;

  always_comb begin
    if (in_cmd == aes128_pkg::CmdDecrypt) begin
      s_nxt = aes128_pkg::dec_round(in_s, dkey, idx == 4'd1);
    end else begin
      s_nxt = aes128_pkg::enc_round(in_s, ekey, idx == 4'd10);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_r <= in_cmd;
      s_r   <= s_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_cmd = cmd_r;
  assign out_s   = s_r;

endmodule

// ----- rtl/core/aes128_block_cipher_unit.sv -----
// AES-128 encrypt/decrypt top level: key registers, round pipeline, output stage.
// Usage:
//   Write key_high at cfg address 0x0 and key_low at 0x8 (64-bit APB data)
//   while the pipeline is empty; in_tready stays low after reset and after
//   every cfg write while the round keys settle.
//   Input requests: in_tdata = {block_low, block_high}, in_tuser = command
//   (0 encrypt, 1 decrypt). Results: out_tdata = {result_low, result_high}.
// Throughput: one block per cycle unless the output stalls; an input stage,
// ten round stages and a final stage (add-key for decrypt) lead to out_tvalid.
// The pipeline advances as one unit: when the output register holds a
// request the receiver has not taken, every stage holds and in_tready drops,
// so nothing is lost or repeated. Otherwise in_tready is high whenever the
// output register is empty or being taken this cycle and the keys have settled.
// Reset (rst_n low, synchronous) clears the key to zero and all valid bits.
module aes128_block_cipher_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,  // block_high[63:0], block_low[127:64]
  input  logic         in_tuser,  // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata, // result_high[63:0], result_low[127:64]
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic [63:0] key_hi_r;
  logic [63:0] key_lo_r;
  logic        wr;
  logic [1:0]  reg_idx;
  logic [3:0]  settle_r;

  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = {1'b0, cfg_paddr[3]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
    end else if (wr && cfg_paddr[2:0] == 3'd0) begin
      if (cfg_paddr[3] == aes128_pkg::AddrKeyHigh[0]) begin
        key_hi_r <= cfg_pwdata;
      end else begin
        key_lo_r <= cfg_pwdata;
      end
    end
  end

  // hold off requests until the round key chain has caught up with the key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= aes128_pkg::KeySettle;
    end else if (wr) begin
      settle_r <= aes128_pkg::KeySettle;
    end else if (settle_r != 4'd0) begin
      settle_r <= settle_r - 4'd1;
    end
  end

  always_comb begin
    unique case (reg_idx)
      aes128_pkg::AddrKeyHigh: cfg_prdata = key_hi_r;
      aes128_pkg::AddrKeyLow:  cfg_prdata = key_lo_r;
      default:                 cfg_prdata = '0;
    endcase
  end

  aes128_pkg::blk_t [10:0] rk;

  aes128_keyexp u_keyexp (
    .clk (clk),
    .key ({key_hi_r, key_lo_r}),
    .rk  (rk)
  );

  logic en;
  logic out_vld_r;
  assign en        = !out_vld_r || out_tready;
  assign in_tready = en && (settle_r == 4'd0);

  // input stage: initial add-key for encrypt; decrypt takes its first key in round one
  logic             v0_r;
  logic             c0_r;
  aes128_pkg::blk_t s0_r;
  aes128_pkg::blk_t blk_in;
  assign blk_in = {in_tdata[63:0], in_tdata[127:64]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid && in_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0_r <= in_tuser;
      s0_r <= (in_tuser == aes128_pkg::CmdDecrypt) ? blk_in : (blk_in ^ rk[0]);
    end
  end

  logic             [10:0] v;
  logic             [10:0] c;
  aes128_pkg::blk_t [10:0] s;
  assign v[0] = v0_r;
  assign c[0] = c0_r;
  assign s[0] = s0_r;

  for (genvar g = 1; g <= 10; g++) begin : g_rnd
    aes128_round u_round (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .idx     (4'(g)),
      .in_vld  (v[g - 1]),
      .in_cmd  (c[g - 1]),
      .in_s    (s[g - 1]),
      .ekey    (rk[g]),
      .dkey    (rk[11 - g]),
      .out_vld (v[g]),
      .out_cmd (c[g]),
      .out_s   (s[g])
    );
  end

  // final stage: decrypt adds round key 0; encrypt already done
  aes128_pkg::blk_t res_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= v[10];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= (c[10] == aes128_pkg::CmdDecrypt) ? (s[10] ^ rk[0]) : s[10];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {res_r[63:0], res_r[127:64]};

endmodule
